### rtl/esrs_pkg.sv
// Package for the engine start ramp sequencer.
// Holds payload and control structs, phase and register codes, and arithmetic constants.
// No dependencies.
package esrs_pkg;

  // Sequencer phases as seen on the result channel.
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_WAIT    = 3'd1;
  localparam logic [2:0] PH_STARTER = 3'd2;
  localparam logic [2:0] PH_UP      = 3'd3;
  localparam logic [2:0] PH_DOWN    = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_IDLE_ANGLE   = 3'd0;
  localparam logic [2:0] REG_MAX_ANGLE    = 3'd1;
  localparam logic [2:0] REG_STARTER_TIME = 3'd2;
  localparam logic [2:0] REG_RAMP_UP      = 3'd3;
  localparam logic [2:0] REG_RAMP_DOWN    = 3'd4;

  localparam logic [7:0]  RST_IDLE_ANGLE   = 8'd30;
  localparam logic [7:0]  RST_MAX_ANGLE    = 8'd150;
  localparam logic [15:0] RST_STARTER_TIME = 16'd1000;
  localparam logic [15:0] RST_RAMP_UP      = 16'd1000;
  localparam logic [15:0] RST_RAMP_DOWN    = 16'd1000;

  localparam logic [6:0] PCT_MIN  = 7'd5;
  localparam logic [6:0] PCT_MAX  = 7'd100;
  localparam logic [6:0] TGT_SPAN = 7'd95;

  // x / 95 equals (x * TGT_RECIP) >> TGT_SHIFT for every x below 30840, and the
  // target numerator never exceeds 255 * 95.
  localparam logic [14:0] TGT_RECIP = 15'd22076;
  localparam int unsigned TGT_SHIFT = 21;

  // Divider geometry: ramp numerators stay below 2^24, durations fit 16 bits.
  localparam int unsigned DIV_W   = 24;
  localparam int unsigned DEN_W   = 16;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

  typedef struct packed {
    logic        start_pressed;
    logic        stop_pressed;
    logic        stop_cooldown;
    logic [7:0]  servo_position;
    logic [6:0]  target_percent;
    logic [31:0] now_ms;
  } esrs_item_t;

  typedef struct packed {
    logic       starter_engaged;
    logic       servo_write;
    logic [7:0] servo_angle;
    logic [2:0] phase;
  } esrs_result_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic eval;
    logic div_start;
    logic load_tgt;
    logic load_out;
  } esrs_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_div;
    logic tgt_only;
    logic div_done;
    logic out_free;
  } esrs_sts_t;

endpackage

### rtl/esrs_intf.sv
// Handshake channel interfaces of the engine start ramp sequencer.
// Depends on esrs_pkg for the payload types.
interface esrs_item_if import esrs_pkg::*; ();
  logic       valid;
  logic       ready;
  esrs_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface esrs_result_if import esrs_pkg::*; ();
  logic         valid;
  logic         ready;
  esrs_result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface esrs_cfg_if import esrs_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/engine_start_ramp_sequencer.sv
// Engine start ramp sequencer. Each item is one control update and yields exactly one result
// item. An item goes from acceptance through evaluation to the output register when no
// arithmetic is needed, through evaluation and a multiply step at the end of the ramp up, when
// the target angle is formed by a reciprocal multiply, and through evaluation, a multiply step
// and the 24-step restoring divider in the datapath while ramping. The result is loaded once the
// output register is free, and the next item can be accepted in the cycle after that load.
// Configuration writes are taken in any cycle and must only be made while the block is idle.
// Uses esrs_pkg, esrs_intf, esrs_ctrl and esrs_dp.
module engine_start_ramp_sequencer import esrs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  esrs_item_if.sink            item_i,
  esrs_result_if.source        result_o,
  esrs_cfg_if.sink             cfg_i
);

  esrs_cmd_t cmd;
  esrs_sts_t sts;

  assign cfg_i.ready = 1'b1;

  esrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .sts_i      (sts),
    .in_ready_o (item_i.ready),
    .cmd_o      (cmd)
  );

  esrs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .item_i      (item_i.data),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .out_ready_i (result_o.ready),
    .out_valid_o (result_o.valid),
    .out_data_o  (result_o.data)
  );

endmodule

### rtl/esrs_div.sv
// Restoring divider, one quotient bit per cycle, for the ramp interpolation.
// Depends on esrs_pkg for the operand widths.
module esrs_div import esrs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DIV_W-1:0]   dividend_i,
  input  logic [DEN_W-1:0]   divisor_i,
  output logic               done_o,
  output logic [DIV_W-1:0]   quotient_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0]     rem_q, rem_d;
  logic [DEN_W-1:0]     den_q, den_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DEN_W:0]       trial;
  logic                 fits;

  // The dividend shifts out at the top while quotient bits enter at the bottom.
  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_W - 1);
      rem_d  = '0;
      den_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### rtl/esrs_dp.sv
// Datapath of the engine start ramp sequencer: configuration, sequencer state,
// operand multipliers, the shared divider and the result register. Uses esrs_pkg, esrs_div.
module esrs_dp import esrs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  esrs_cmd_t    cmd_i,
  output esrs_sts_t    sts_o,
  input  esrs_item_t   item_i,
  input  logic         cfg_valid_i,
  input  logic [2:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i,
  input  logic         out_ready_i,
  output logic         out_valid_o,
  output esrs_result_t out_data_o
);

  // Configuration registers.
  logic [7:0]  idle_q, max_q;
  logic [15:0] starter_q, up_q, down_q;

  // Sequencer state.
  logic [2:0]  phase_q, phase_d;
  logic        in_prog_q, in_prog_d;
  logic [31:0] start_ms_q, start_ms_d;
  logic [7:0]  from_q, from_d;
  logic [7:0]  to_q, to_d;
  logic        crank_q, crank_d;

  // Item and pending result.
  esrs_item_t  item_q;
  logic        res_wr_q, res_wr_d;
  logic [7:0]  res_ang_q, res_ang_d;
  logic        tgt_mode_q, tgt_mode_d;

  // Multiplier outputs and divisor, registered ahead of the divider.
  logic [DIV_W-1:0]        prod_a_q, prod_a_d;
  logic signed [DIV_W+1:0] prod_b_q, prod_b_d;
  logic [DEN_W-1:0]        den_q, den_d;

  logic              out_valid_q;
  esrs_result_t      out_data_q;

  logic              div_done;
  logic [DIV_W-1:0]  quotient;
  logic [DIV_W+1:0]  num_sum;
  logic [29:0]       tgt_prod;

  logic [31:0]       elapsed;
  logic [15:0]       dur_up, dur_down, dur_sel;
  logic [6:0]        pct_sat, pct_off;
  logic [7:0]        pos_diff;
  logic              need_div;
  logic signed [8:0] span_tgt, span_int;
  logic signed [16:0] elapsed_s;
  logic signed [7:0] pct_off_s;
  logic [DIV_W-1:0]  a_int, a_tgt;
  logic signed [DIV_W+1:0] b_int, b_tgt;

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q    <= RST_IDLE_ANGLE;
      max_q     <= RST_MAX_ANGLE;
      starter_q <= RST_STARTER_TIME;
      up_q      <= RST_RAMP_UP;
      down_q    <= RST_RAMP_DOWN;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_IDLE_ANGLE:   idle_q    <= cfg_data_i[7:0];
        REG_MAX_ANGLE:    max_q     <= cfg_data_i[7:0];
        REG_STARTER_TIME: starter_q <= cfg_data_i;
        REG_RAMP_UP:      up_q      <= cfg_data_i;
        REG_RAMP_DOWN:    down_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign elapsed  = item_q.now_ms - start_ms_q;
  assign dur_up   = (up_q == '0) ? 16'd1 : up_q;
  assign dur_down = (down_q == '0) ? 16'd1 : down_q;
  assign dur_sel  = (phase_q == PH_UP) ? dur_up : dur_down;
  assign pct_sat  = (item_q.target_percent > PCT_MAX) ? PCT_MAX : item_q.target_percent;
  assign pct_off  = pct_sat - PCT_MIN;
  assign pos_diff = (item_q.servo_position > idle_q) ? item_q.servo_position - idle_q
                                                     : idle_q - item_q.servo_position;

  // Operands for num = a + b; in a ramp the quotient num / den is the commanded angle, and for
  // the target num / 95 is the target angle. Within a ramp the elapsed time is below the duration, so it fits 16 bits.
  assign span_tgt  = $signed({1'b0, max_q}) - $signed({1'b0, idle_q});
  assign span_int  = $signed({1'b0, to_q}) - $signed({1'b0, from_q});
  assign elapsed_s = $signed({1'b0, elapsed[15:0]});
  assign pct_off_s = $signed({1'b0, pct_off});
  assign a_int     = DIV_W'(from_q) * DIV_W'(dur_sel);
  assign a_tgt     = DIV_W'(idle_q) * DIV_W'(TGT_SPAN);
  assign b_int     = (DIV_W+2)'(elapsed_s) * (DIV_W+2)'(span_int);
  assign b_tgt     = (DIV_W+2)'(pct_off_s) * (DIV_W+2)'(span_tgt);

  always_comb begin
    phase_d      = phase_q;
    in_prog_d    = in_prog_q;
    start_ms_d   = start_ms_q;
    from_d       = from_q;
    to_d         = to_q;
    crank_d      = crank_q;
    res_wr_d     = 1'b0;
    res_ang_d    = '0;
    need_div     = 1'b0;
    tgt_mode_d   = 1'b0;
    if (item_q.stop_pressed || item_q.stop_cooldown) begin
      in_prog_d    = 1'b0;
      phase_d      = PH_IDLE;
      crank_d      = 1'b0;
      res_wr_d     = 1'b1;
    end else begin
      case (phase_q)
        PH_IDLE: begin
          if (item_q.start_pressed && !in_prog_q) begin
            res_wr_d  = 1'b1;
            res_ang_d = idle_q;
            in_prog_d = 1'b1;
            phase_d   = PH_WAIT;
          end
        end
        PH_WAIT: begin
          if (pos_diff <= 8'd1) begin
            crank_d      = 1'b1;
            start_ms_d   = item_q.now_ms;
            phase_d      = PH_STARTER;
          end
        end
        PH_STARTER: begin
          if (elapsed >= {16'd0, starter_q}) begin
            crank_d      = 1'b0;
            from_d       = idle_q;
            to_d         = max_q;
            start_ms_d   = item_q.now_ms;
            phase_d      = PH_UP;
          end
        end
        PH_UP: begin
          res_wr_d = 1'b1;
          if (elapsed >= {16'd0, dur_up}) begin
            res_ang_d  = max_q;
            from_d     = max_q;
            start_ms_d = item_q.now_ms;
            phase_d    = PH_DOWN;
            // Below the minimum percent the target is zero; otherwise it is worked out
            // by the reciprocal multiply.
            if (pct_sat < PCT_MIN) begin
              to_d = '0;
            end else begin
              need_div   = 1'b1;
              tgt_mode_d = 1'b1;
            end
          end else begin
            need_div = 1'b1;
          end
        end
        PH_DOWN: begin
          res_wr_d = 1'b1;
          if (elapsed >= {16'd0, dur_down}) begin
            res_ang_d = to_q;
            phase_d   = PH_IDLE;
            in_prog_d = 1'b0;
          end else begin
            need_div = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign prod_a_d = tgt_mode_d ? a_tgt : a_int;
  assign prod_b_d = tgt_mode_d ? b_tgt : b_int;
  assign den_d    = dur_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      in_prog_q    <= 1'b0;
      start_ms_q   <= '0;
      from_q       <= '0;
      to_q         <= '0;
      crank_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.eval) begin
        phase_q      <= phase_d;
        in_prog_q    <= in_prog_d;
        start_ms_q   <= start_ms_d;
        from_q       <= from_d;
        to_q         <= to_d;
        crank_q      <= crank_d;
      end else if (cmd_i.load_tgt) begin
        to_q <= tgt_prod[TGT_SHIFT+7:TGT_SHIFT];
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= item_i;
    end
    if (cmd_i.eval) begin
      res_wr_q   <= res_wr_d;
      res_ang_q  <= res_ang_d;
      tgt_mode_q <= tgt_mode_d;
      prod_a_q   <= prod_a_d;
      prod_b_q   <= prod_b_d;
      den_q      <= den_d;
    end else if (div_done) begin
      res_ang_q <= quotient[7:0];
    end
    if (cmd_i.load_out) begin
      out_data_q.starter_engaged <= crank_q;
      out_data_q.servo_write     <= res_wr_q;
      out_data_q.servo_angle     <= res_wr_q ? res_ang_q : 8'd0;
      out_data_q.phase           <= phase_q;
    end
  end

  // Wherever it is used, the numerator is never negative and stays below 2^24.
  assign num_sum  = $unsigned($signed({2'b00, prod_a_q}) + prod_b_q);
  assign tgt_prod = num_sum[14:0] * TGT_RECIP;

  esrs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (num_sum[DIV_W-1:0]),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign sts_o.need_div = need_div;
  assign sts_o.tgt_only = tgt_mode_q;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;

endmodule

### rtl/esrs_ctrl.sv
// Controller of the engine start ramp sequencer: steps one item through
// evaluate, then multiply and divide as needed, and hand-off. Uses esrs_pkg command and status types.
module esrs_ctrl import esrs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  esrs_sts_t sts_i,
  output logic      in_ready_o,
  output esrs_cmd_t cmd_o
);

  localparam logic [2:0] ST_IN   = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_PUT  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IN:   if (in_valid_i) state_d = ST_EVAL;
      ST_EVAL: state_d = sts_i.need_div ? ST_MUL : ST_PUT;
      // The target angle is finished here; only ramp points go through the divider.
      ST_MUL:  state_d = sts_i.tgt_only ? ST_PUT : ST_DIV;
      ST_DIV:  if (sts_i.div_done) state_d = ST_PUT;
      ST_PUT:  if (sts_i.out_free) state_d = ST_IN;
      default: state_d = ST_IN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IN;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o      = (state_q == ST_IN);
  assign cmd_o.accept    = (state_q == ST_IN) && in_valid_i;
  assign cmd_o.eval      = (state_q == ST_EVAL);
  assign cmd_o.div_start = (state_q == ST_MUL) && !sts_i.tgt_only;
  assign cmd_o.load_tgt  = (state_q == ST_MUL) && sts_i.tgt_only;
  assign cmd_o.load_out  = (state_q == ST_PUT) && sts_i.out_free;

endmodule
